// ===== hdl/cfvt_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cfvt_pkg
// Shared widths, constants and types of the capture-driven VCO tuner.
// ---------------------------------------------------------------------------
package cfvt_pkg;

    localparam int STAMP_BITS = 16;
    localparam int DAC_BITS   = 12;
    localparam int CODE_BITS  = 2 * DAC_BITS;
    localparam int CLOCK_BITS = 28;
    localparam int FREQ_BITS  = 32;
    localparam int CFG_BITS   = 32;

    // timer clock is core clock / 2, so the dividend loses one bit
    localparam int DVD_BITS   = CLOCK_BITS - 1;
    localparam int DIV_STEPS  = DVD_BITS;
    localparam int CNT_BITS   = 5;
    localparam int PRE_SHIFT  = 3;

    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
    localparam logic [CODE_BITS-1:0]  CODE_MAX  = '1;
    localparam logic [DAC_BITS-1:0]   HALF_MID  = {1'b0, {(DAC_BITS-1){1'b1}}};
    localparam logic [CODE_BITS-1:0]  CODE_RESET = {HALF_MID, HALF_MID};
    localparam logic [CLOCK_BITS-1:0] CLOCK_RESET = CLOCK_BITS'(168000000);
    localparam logic [FREQ_BITS-1:0]  FREQ_SAT  = '1;

    typedef enum logic [0:0] {
        REG_CORE_CLOCK = 1'b0,
        REG_TARGET     = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic                  second;
        logic [STAMP_BITS-1:0] period;
    } queue_entry_t;

endpackage : cfvt_pkg
`default_nettype wire

// ===== hdl/cfvt_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cfvt_front
// Accepts capture stamps, tracks the pair phase and forms the period.
// ---------------------------------------------------------------------------
module cfvt_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [cfvt_pkg::STAMP_BITS-1:0] s_stamp,
    output logic                                push,
    output cfvt_pkg::queue_entry_t              push_entry,
    input  wire logic                           q_full
);

    logic                          pair_phase_reg, pair_phase_next;
    logic [cfvt_pkg::STAMP_BITS-1:0] first_stamp_reg, first_stamp_next;
    logic [cfvt_pkg::STAMP_BITS-1:0] period;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        if (s_stamp > first_stamp_reg) begin
            period = s_stamp - first_stamp_reg;
        end else if (s_stamp < first_stamp_reg) begin
            // wrap formula kept one short of a true modulo
            period = (cfvt_pkg::STAMP_MAX - first_stamp_reg) + s_stamp;
        end else begin
            period = '0;
        end
    end

    always_comb begin
        push_entry.second = pair_phase_reg;
        push_entry.period = period;
        pair_phase_next   = pair_phase_reg;
        first_stamp_next  = first_stamp_reg;
        if (push) begin
            pair_phase_next = !pair_phase_reg;
            if (!pair_phase_reg) begin
                first_stamp_next = s_stamp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_phase_reg  <= 1'b0;
            first_stamp_reg <= '0;
        end else begin
            pair_phase_reg  <= pair_phase_next;
            first_stamp_reg <= first_stamp_next;
        end
    end

endmodule : cfvt_front
`default_nettype wire

// ===== hdl/cfvt_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cfvt_queue
// Two-entry queue between the classifying front and the divide back end.
// ---------------------------------------------------------------------------
module cfvt_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire cfvt_pkg::queue_entry_t push_entry,
    output logic                        full,
    input  wire logic                   pop,
    output logic                        q_valid,
    output cfvt_pkg::queue_entry_t      pop_entry
);

    cfvt_pkg::queue_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign q_valid   = (count_reg != 2'd0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : cfvt_queue
`default_nettype wire

// ===== hdl/cfvt_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cfvt_back
// Config registers, bit-serial frequency divide, bang-bang code step and
// the output register.
// ---------------------------------------------------------------------------
module cfvt_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [0:0]                     cfg_addr,
    input  wire logic [cfvt_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  wire logic                           q_valid,
    input  wire cfvt_pkg::queue_entry_t         q_entry,
    output logic                                pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [cfvt_pkg::DAC_BITS-1:0]       m_coarse,
    output logic [cfvt_pkg::DAC_BITS-1:0]       m_fine,
    output logic [cfvt_pkg::FREQ_BITS-1:0]      m_freq,
    output logic                                m_updated
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_STEP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [cfvt_pkg::CLOCK_BITS-1:0] clock_reg, clock_next;
    logic [cfvt_pkg::FREQ_BITS-1:0]  target_reg, target_next;
    logic [cfvt_pkg::FREQ_BITS-1:0]  freq_reg, freq_next;
    logic [cfvt_pkg::CODE_BITS-1:0]  code_reg, code_next;
    logic                            upd_reg, upd_next;

    logic [cfvt_pkg::STAMP_BITS-1:0] div_reg, div_next;
    logic [cfvt_pkg::STAMP_BITS-1:0] rem_reg, rem_next;
    logic [cfvt_pkg::DVD_BITS-1:0]   dvd_reg, dvd_next;
    logic [cfvt_pkg::DVD_BITS-1:0]   quo_reg, quo_next;
    logic [cfvt_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [cfvt_pkg::STAMP_BITS:0]   trial;
    logic                            qbit;

    logic                            m_valid_reg, m_valid_next;
    logic [cfvt_pkg::DAC_BITS-1:0]   coarse_reg, coarse_next;
    logic [cfvt_pkg::DAC_BITS-1:0]   fine_reg, fine_next;
    logic [cfvt_pkg::FREQ_BITS-1:0]  mfreq_reg, mfreq_next;
    logic                            mupd_reg, mupd_next;

    logic                            load;
    logic                            up;
    logic [cfvt_pkg::CODE_BITS-1:0]  code_step;

    assign pop       = (state_reg == ST_IDLE) && q_valid;
    assign load      = (state_reg == ST_STEP) && (!m_valid_reg || m_tready);
    assign m_tvalid  = m_valid_reg;
    assign m_coarse  = coarse_reg;
    assign m_fine    = fine_reg;
    assign m_freq    = mfreq_reg;
    assign m_updated = mupd_reg;

    // restoring divide, one quotient bit a cycle
    assign trial = {rem_reg, dvd_reg[cfvt_pkg::DVD_BITS-1]};
    assign qbit  = (trial >= {1'b0, div_reg});

    always_comb begin
        up = !(freq_reg > target_reg);
        if (up && (code_reg != cfvt_pkg::CODE_MAX)) begin
            code_step = code_reg + 1'b1;
        end else if (code_reg != '0) begin
            code_step = code_reg - 1'b1;
        end else begin
            code_step = code_reg;
        end
    end

    always_comb begin
        clock_next  = clock_reg;
        target_next = target_reg;
        if (cfg_we) begin
            case (cfg_addr)
                cfvt_pkg::REG_CORE_CLOCK:
                    clock_next = cfg_wdata[cfvt_pkg::CLOCK_BITS-1:0];
                cfvt_pkg::REG_TARGET:
                    target_next = cfg_wdata[cfvt_pkg::FREQ_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        freq_next    = freq_reg;
        code_next    = code_reg;
        upd_next     = upd_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        coarse_next  = coarse_reg;
        fine_next    = fine_reg;
        mfreq_next   = mfreq_reg;
        mupd_next    = mupd_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    upd_next = q_entry.second;
                    div_next = q_entry.period;
                    rem_next = '0;
                    dvd_next = clock_reg[cfvt_pkg::CLOCK_BITS-1:1];
                    quo_next = '0;
                    cnt_next = '0;
                    if (!q_entry.second) begin
                        state_next = ST_STEP;
                    end else if (q_entry.period == '0) begin
                        freq_next  = cfvt_pkg::FREQ_SAT;
                        state_next = ST_STEP;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next = qbit ? cfvt_pkg::STAMP_BITS'(trial - {1'b0, div_reg})
                                : trial[cfvt_pkg::STAMP_BITS-1:0];
                dvd_next = {dvd_reg[cfvt_pkg::DVD_BITS-2:0], 1'b0};
                quo_next = {quo_reg[cfvt_pkg::DVD_BITS-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == cfvt_pkg::CNT_BITS'(cfvt_pkg::DIV_STEPS - 1)) begin
                    freq_next  = cfvt_pkg::FREQ_BITS'(
                        {quo_reg[cfvt_pkg::DVD_BITS-2:0], qbit}) << cfvt_pkg::PRE_SHIFT;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (load) begin
                    code_next    = code_step;
                    m_valid_next = 1'b1;
                    coarse_next  = code_step[cfvt_pkg::CODE_BITS-1:cfvt_pkg::DAC_BITS];
                    fine_next    = code_step[cfvt_pkg::DAC_BITS-1:0];
                    mfreq_next   = freq_reg;
                    mupd_next    = upd_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        quo_reg    <= quo_next;
        coarse_reg <= coarse_next;
        fine_reg   <= fine_next;
        mfreq_reg  <= mfreq_next;
        mupd_reg   <= mupd_next;
        upd_reg    <= upd_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            clock_reg   <= cfvt_pkg::CLOCK_RESET;
            target_reg  <= '0;
            freq_reg    <= '0;
            code_reg    <= cfvt_pkg::CODE_RESET;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            target_reg  <= target_next;
            freq_reg    <= freq_next;
            code_reg    <= code_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule : cfvt_back
`default_nettype wire

// ===== hdl/capture_freq_bang_bang_vco_tuner.sv =====
// Path: a first stamp or a zero-period second goes from the queue through
//   the step state to m_tvalid; any other second stamp first passes the
//   27-step divider. The back end takes a new stamp only once it is back
//   in idle; a two-entry queue lets the front accept while the divider runs.
// Reset: aresetn synchronous, active low; restores config, pair phase,
//   frequency and tune code. No clearing pass.
`default_nettype none
// ---------------------------------------------------------------------------
// capture_freq_bang_bang_vco_tuner
// Bang-bang frequency-locked VCO tuner fed by input-capture timestamps.
// ---------------------------------------------------------------------------
module capture_freq_bang_bang_vco_tuner (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] capture_stamp
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [11:0] coarse_dac, [23:12] fine_dac,
                                        // [55:24] measured_freq
    output logic             m_tuser    // [0] freq_updated
);

    logic                   push, q_full, pop, q_valid;
    cfvt_pkg::queue_entry_t push_entry, pop_entry;
    logic [cfvt_pkg::DAC_BITS-1:0]  coarse, fine;
    logic [cfvt_pkg::FREQ_BITS-1:0] freq;

    cfvt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_stamp    (s_tdata),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    cfvt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .pop_entry  (pop_entry)
    );

    cfvt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_entry   (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_coarse  (coarse),
        .m_fine    (fine),
        .m_freq    (freq),
        .m_updated (m_tuser)
    );

    assign m_tdata = {freq, fine, coarse};

endmodule : capture_freq_bang_bang_vco_tuner
`default_nettype wire

// ===== hdl/cfvt_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cfvt_checker
// Port-level checks of the tuner, bound to the top level.
// ---------------------------------------------------------------------------
module cfvt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic        m_tuser
);

    // nothing comes out right after reset
    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // queue is empty after reset, so the input side is open
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // a stalled result holds its payload
    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule : cfvt_checker

bind capture_freq_bang_bang_vco_tuner cfvt_checker u_cfvt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/sv/cfvt_tuner_checker.sv =====
// ---------------------------------------------------------------------------
// cfvt_tuner_checker
// Watches the register port and both streams of the capture-driven VCO
// tuner, predicts the DAC words and frequency of every accepted stamp, and
// compares each returned result with the oldest prediction.
// ---------------------------------------------------------------------------
module cfvt_tuner_checker
    import cfvt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] capture_stamp
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,   // [11:0] coarse_dac, [23:12] fine_dac,
                                        // [55:24] measured_freq
    input  wire logic        m_tuser,   // [0] freq_updated
    output int               bad_words,
    output int               words_pending,
    output int               words_checked,
    output int               pairs_closed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DAC_BITS-1:0]  coarse;
        logic [DAC_BITS-1:0]  fine;
        logic [FREQ_BITS-1:0] freq;
        logic                 updated;
    } tuner_word_t;

    // model state, updated with blocking assignments inside one process
    logic [CLOCK_BITS-1:0] core_clock;
    logic [FREQ_BITS-1:0]  target_freq;
    logic                  want_second;
    logic [STAMP_BITS-1:0] first_stamp;
    logic [FREQ_BITS-1:0]  held_freq;
    logic [CODE_BITS-1:0]  tune_code;
    logic                  refreshed;
    tuner_word_t           words_due[$];
    tuner_word_t           want;
    tuner_word_t           got;
    int                    n_bad;
    int                    n_checked;
    int                    n_pairs;

    function automatic logic [FREQ_BITS-1:0] stamps_to_freq(
        input logic [STAMP_BITS-1:0] a,
        input logic [STAMP_BITS-1:0] b,
        input logic [CLOCK_BITS-1:0] clk_hz
    );
        logic [STAMP_BITS:0] period;
        logic [63:0]         f;
        if (b > a) begin
            period = b - a;
        end else if (b < a) begin
            // wrap formula loses one count, as in cfvt_front
            period = (STAMP_MAX - a) + b;
        end else begin
            period = '0;
        end
        if (period == '0) begin
            return FREQ_SAT;
        end
        f = ((64'(clk_hz) >> 1) / 64'(period)) << PRE_SHIFT;
        return f[FREQ_BITS-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            core_clock  = CLOCK_RESET;
            target_freq = '0;
            want_second = 1'b0;
            first_stamp = '0;
            held_freq   = '0;
            tune_code   = CODE_RESET;
            words_due.delete();
            n_bad       = 0;
            n_checked   = 0;
            n_pairs     = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CORE_CLOCK: core_clock  = cfg_wdata[CLOCK_BITS-1:0];
                    REG_TARGET:     target_freq = cfg_wdata[FREQ_BITS-1:0];
                    default:        ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                if (!want_second) begin
                    first_stamp = s_tdata;
                    want_second = 1'b1;
                    refreshed   = 1'b0;
                end else begin
                    held_freq   = stamps_to_freq(first_stamp, s_tdata, core_clock);
                    want_second = 1'b0;
                    refreshed   = 1'b1;
                end
                // bang-bang step; an up request at full scale still steps down
                if (!(held_freq > target_freq) && tune_code != CODE_MAX) begin
                    tune_code = tune_code + 1'b1;
                end else if (tune_code != '0) begin
                    tune_code = tune_code - 1'b1;
                end
                words_due.push_back('{coarse:  tune_code[CODE_BITS-1:DAC_BITS],
                                      fine:    tune_code[DAC_BITS-1:0],
                                      freq:    held_freq,
                                      updated: refreshed});
            end

            if (m_tvalid && m_tready) begin
                got = '{coarse:  m_tdata[11:0],
                        fine:    m_tdata[23:12],
                        freq:    m_tdata[55:24],
                        updated: m_tuser};
                if (words_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("[%0t] unexpected result: coarse %h fine %h freq %h upd %b",
                                 $realtime, got.coarse, got.fine, got.freq, got.updated);
                    end
                end else begin
                    want = words_due.pop_front();
                    n_checked++;
                    if (want.updated) begin
                        n_pairs++;
                    end
                    if (got.coarse != want.coarse || got.fine != want.fine ||
                        got.freq != want.freq || got.updated != want.updated) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("[%0t] result %0d mismatch: expected coarse %h fine %h %s",
                                     $realtime, n_checked, want.coarse, want.fine,
                                     $sformatf("freq %h upd %b", want.freq, want.updated));
                            $display("    got coarse %h fine %h freq %h upd %b",
                                     got.coarse, got.fine, got.freq, got.updated);
                        end
                    end
                end
            end
        end

        bad_words     <= n_bad;
        words_pending <= words_due.size();
        words_checked <= n_checked;
        pairs_closed  <= n_pairs;
    end

endmodule : cfvt_tuner_checker

// ===== tb/sv/tb_capture_freq_bang_bang_vco_tuner.sv =====
// ---------------------------------------------------------------------------
// tb_capture_freq_bang_bang_vco_tuner
// Drives capture stamps and register writes into the VCO tuner, with random
// idling on both streams and a long receiver hold-off; the checker beside
// the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_capture_freq_bang_bang_vco_tuner;
    timeunit 1ns;
    timeprecision 1ps;
    import cfvt_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_STAMPS  = 250;
    localparam int NUM_PHASES    = 7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_addr = REG_CORE_CLOCK;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;

    int bad_words;
    int words_pending;
    int words_checked;
    int pairs_closed;

    int sender_idle_pct   = 10;
    int receiver_idle_pct = 53;
    int holds_asked = 0;
    int holds_done  = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;
    int stamps_sent  = 0;
    int settings_used = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    capture_freq_bang_bang_vco_tuner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    cfvt_tuner_checker tuner_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .bad_words     (bad_words),
        .words_pending (words_pending),
        .words_checked (words_checked),
        .pairs_closed  (pairs_closed)
    );

    // result side: random back-pressure, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            m_tready   <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, words_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic offer_stamp(input logic [15:0] stamp);
        s_tdata  <= stamp;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        stamps_sent++;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic offer_pair(input logic [15:0] a, input logic [15:0] b);
        offer_stamp(a);
        offer_stamp(b);
    endtask

    // stop offering, wait for every outstanding result, then let the divider drain
    task automatic settle_tuner();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_tuner(input logic [31:0] clock_word, input logic [31:0] target_word);
        settle_tuner();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_CORE_CLOCK;
        cfg_wdata <= clock_word;
        @(posedge aclk);
        cfg_addr  <= REG_TARGET;
        cfg_wdata <= target_word;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [31:0] clock_word;
        logic [31:0] target_word;
        logic [63:0] timer_hz;
        logic [15:0] first;
        int          nominal;
        int          jitter;
        int          pick;
        int          phase_start;
        bit          hold_sent;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: 168 MHz core clock, target zero
        settings_used = 1;
        offer_pair(16'h0000, 16'hFFFF);     // longest forward period
        offer_pair(16'hFFFF, 16'h0000);     // wrap formula gives a zero period
        offer_pair(16'h1234, 16'h1234);     // equal stamps saturate
        offer_pair(16'hFFFF, 16'hFFFF);
        offer_pair(16'h0000, 16'h0001);     // shortest period, highest frequency
        offer_pair(16'h8000, 16'h7FFF);     // wrap
        offer_pair(16'h0001, 16'h0000);
        offer_pair(16'hAAAA, 16'h5555);
        offer_pair(16'h5555, 16'hAAAA);
        offer_pair(16'h0100, 16'h1168);

        hold_sent = 1'b0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            nominal = $urandom_range(40, 3000);
            jitter  = nominal / 64 + 1;
            case (phase)
                0: clock_word = 32'd168000000 | ($urandom & 32'hF000_0000);
                1: clock_word = 32'h0FFF_FFFF;
                2: clock_word = 32'h0000_0000;
                5: clock_word = 32'd168000000;
                6: clock_word = 32'hFFFF_FFFF;
                default: clock_word = $urandom;
            endcase
            timer_hz = 64'(clock_word[CLOCK_BITS-1:0]) >> 1;
            case (phase)
                2: target_word = 32'h0000_0000;
                3: target_word = 32'hFFFF_FFFF;
                4: target_word = $urandom;
                default: target_word = 32'((timer_hz / 64'(nominal)) * 8);
            endcase
            load_tuner(clock_word, target_word);

            if (phase < 3) begin
                sender_idle_pct   = 10;
                receiver_idle_pct = 53;
            end else if (phase < 5) begin
                sender_idle_pct   = 53;
                receiver_idle_pct = 10;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end

            phase_start = stamps_sent;
            while (stamps_sent - phase_start < PHASE_STAMPS) begin
                // one long receiver hold while stamps keep coming
                if (phase == 1 && !hold_sent && stamps_sent - phase_start >= 80) begin
                    holds_asked <= holds_asked + 1;
                    hold_sent = 1'b1;
                end
                pick  = $urandom_range(99);
                first = 16'($urandom);
                if (pick < 70) begin
                    offer_pair(first, first + 16'(nominal - jitter + $urandom_range(0, 2 * jitter)));
                end else if (pick < 78) begin
                    offer_pair(first, first);
                end else if (pick < 88) begin
                    offer_pair(first, first - 16'($urandom_range(1, 3000)));
                end else if (pick < 95) begin
                    offer_pair(first, 16'($urandom));
                end else begin
                    offer_stamp(first);     // lone stamp shifts the pairing
                end
            end
        end

        settle_tuner();
        $display("Sent %0d capture stamps over %0d tuner settings; checked %0d results, %0d %s",
                 stamps_sent, settings_used, words_checked, pairs_closed,
                 "of them completed pairs");
        if (bad_words == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule : tb_capture_freq_bang_bang_vco_tuner
